// ----- design/hcl_pkg.sv -----
// hcl_pkg: shared types and constants of the hex cell locator.
// Used by hcl_divider, hcl_nearest and hex_cell_locator; no dependencies.
package hcl_pkg;

    localparam int POS_W      = 16;
    localparam int HW_W       = 10;
    localparam int RP_W       = 11;
    localparam int DIV_STAGES = POS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH  = 2'd1;

    localparam logic [HW_W-1:0] HALF_WIDTH_RST = 10'd50;
    localparam logic [RP_W-1:0] ROW_PITCH_RST  = 11'd86;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } hcl_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] cell_col;
        logic signed [POS_W-1:0] cell_row;
        logic                    found;
    } hcl_out_t;

    // Sign info and the original point, carried alongside the divider.
    typedef struct packed {
        logic                    neg_x;
        logic                    neg_y;
        logic                    nz_x;
        logic                    nz_y;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } hcl_meta_t;

    // One divider lane: partial remainder and dividend/quotient shifter.
    typedef struct packed {
        logic [RP_W-1:0]  rem;
        logic [POS_W-1:0] dq;
    } hcl_lane_t;

    typedef struct packed {
        logic             valid;
        hcl_meta_t        meta;
        logic [POS_W-1:0] qx_mag;
        logic [POS_W-1:0] qy_mag;
    } hcl_quot_t;

endpackage

// ----- design/hcl_divider.sv -----
// hcl_divider: two-lane restoring divider, one quotient bit per stage.
// Depends on hcl_pkg.
module hcl_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  hcl_pkg::hcl_meta_t            in_meta,
    input  logic [hcl_pkg::POS_W-1:0]     x_mag,
    input  logic [hcl_pkg::POS_W-1:0]     y_mag,
    input  logic [hcl_pkg::HW_W-1:0]      half_width,
    input  logic [hcl_pkg::RP_W-1:0]      row_pitch,
    output hcl_pkg::hcl_quot_t            quot
);

    localparam int N = hcl_pkg::DIV_STAGES;

    logic               vld_reg  [N];
    hcl_pkg::hcl_meta_t meta_reg [N];
    hcl_pkg::hcl_lane_t lx_reg   [N];
    hcl_pkg::hcl_lane_t ly_reg   [N];
    hcl_pkg::hcl_lane_t lx_next  [N];
    hcl_pkg::hcl_lane_t ly_next  [N];

    logic [hcl_pkg::RP_W-1:0] dvx;

    assign dvx = {{(hcl_pkg::RP_W-hcl_pkg::HW_W){1'b0}}, half_width};

    function automatic hcl_pkg::hcl_lane_t div_step(hcl_pkg::hcl_lane_t l,
                                                     logic [hcl_pkg::RP_W-1:0] d);
        logic [hcl_pkg::RP_W:0] t;
        logic [hcl_pkg::RP_W:0] s;
        hcl_pkg::hcl_lane_t     r;
        t = {l.rem, l.dq[hcl_pkg::POS_W-1]};
        s = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            r.rem = s[hcl_pkg::RP_W-1:0];
            r.dq  = {l.dq[hcl_pkg::POS_W-2:0], 1'b1};
        end else begin
            r.rem = t[hcl_pkg::RP_W-1:0];
            r.dq  = {l.dq[hcl_pkg::POS_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb begin
        lx_next[0] = div_step('{rem: '0, dq: x_mag}, dvx);
        ly_next[0] = div_step('{rem: '0, dq: y_mag}, row_pitch);
        for (int i = 1; i < N; i++) begin
            lx_next[i] = div_step(lx_reg[i-1], dvx);
            ly_next[i] = div_step(ly_reg[i-1], row_pitch);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_reg[0] <= in_meta;
            for (int i = 0; i < N; i++) begin
                lx_reg[i] <= lx_next[i];
                ly_reg[i] <= ly_next[i];
            end
            for (int i = 1; i < N; i++) begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < N; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign quot.valid  = vld_reg[N-1];
    assign quot.meta   = meta_reg[N-1];
    assign quot.qx_mag = lx_reg[N-1].dq;
    assign quot.qy_mag = ly_reg[N-1].dq;

endmodule

// ----- design/hcl_nearest.sv -----
// hcl_nearest: corner build, centre test, distance compare, output register.
// Depends on hcl_pkg.
module hcl_nearest (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  hcl_pkg::hcl_quot_t        quot,
    input  logic [hcl_pkg::HW_W-1:0]  half_width,
    input  logic [hcl_pkg::RP_W-1:0]  row_pitch,
    output logic                      out_valid,
    output hcl_pkg::hcl_out_t         out_data
);

    localparam int IW = hcl_pkg::POS_W + 2;   // lattice index
    localparam int PW = hcl_pkg::POS_W + 4;   // corner position / offset
    localparam int SW = 2 * PW;               // square
    localparam int DW = SW + 1;               // distance sum

    // stage A: chosen corners
    logic                    a_vld_reg, a_fnd_reg;
    logic signed [IW-1:0]    a_ka_reg [2];
    logic signed [IW-1:0]    a_kr_reg [2];
    logic signed [hcl_pkg::POS_W-1:0] a_x_reg, a_y_reg;
    // stage B: corner positions
    logic                    b_vld_reg, b_fnd_reg;
    logic signed [PW-1:0]    b_px_reg [2];
    logic signed [PW-1:0]    b_py_reg [2];
    logic signed [IW-1:0]    b_ka_reg [2];
    logic signed [IW-1:0]    b_kr_reg [2];
    logic signed [hcl_pkg::POS_W-1:0] b_x_reg, b_y_reg;
    // stage C: offsets
    logic                    c_vld_reg, c_fnd_reg;
    logic signed [PW-1:0]    c_dx_reg [2];
    logic signed [PW-1:0]    c_dy_reg [2];
    logic signed [IW-1:0]    c_ka_reg [2];
    logic signed [IW-1:0]    c_kr_reg [2];
    // stage D: squares
    logic                    d_vld_reg, d_fnd_reg;
    logic [SW-1:0]           d_sx_reg [2];
    logic [SW-1:0]           d_sy_reg [2];
    logic signed [IW-1:0]    d_ka_reg [2];
    logic signed [IW-1:0]    d_kr_reg [2];
    // stage E: output
    logic                    e_vld_reg;
    hcl_pkg::hcl_out_t       e_out_reg;

    logic signed [IW-1:0]    qx, qy, sgx, sgy;
    logic signed [IW-1:0]    ca [4];
    logic signed [IW-1:0]    cr [4];
    logic signed [IW-1:0]    ka_next [2];
    logic signed [IW-1:0]    kr_next [2];
    logic                    fnd_next;
    logic [1:0]              n_cnt;
    logic signed [IW+hcl_pkg::RP_W:0] prod_x [2];
    logic signed [IW+hcl_pkg::RP_W:0] prod_y [2];
    logic [DW-1:0]           dist_sum [2];
    logic                    pick;
    hcl_pkg::hcl_out_t       out_next;

    // Signed quotients, neighbor direction, four corners, first two centres.
    always_comb begin
        qx  = quot.meta.neg_x ? -$signed({2'b00, quot.qx_mag}) : $signed({2'b00, quot.qx_mag});
        qy  = quot.meta.neg_y ? -$signed({2'b00, quot.qy_mag}) : $signed({2'b00, quot.qy_mag});
        sgx = !quot.meta.nz_x ? '0 : (quot.meta.neg_x ? '1 : IW'(1));
        sgy = !quot.meta.nz_y ? '0 : (quot.meta.neg_y ? '1 : IW'(1));
        ca[0] = qx;       cr[0] = qy;
        ca[1] = qx + sgx; cr[1] = qy;
        ca[2] = qx;       cr[2] = qy + sgy;
        ca[3] = qx + sgx; cr[3] = qy + sgy;
        n_cnt   = '0;
        ka_next = '{'0, '0};
        kr_next = '{'0, '0};
        for (int i = 0; i < 4; i++) begin
            if (ca[i][0] == cr[i][0] && n_cnt != 2'd2) begin
                ka_next[n_cnt[0]] = ca[i];
                kr_next[n_cnt[0]] = cr[i];
                n_cnt = n_cnt + 2'd1;
            end
        end
        fnd_next = (n_cnt == 2'd2);
    end

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            prod_x[k]   = a_ka_reg[k] * $signed({1'b0, half_width});
            prod_y[k]   = a_kr_reg[k] * $signed({1'b0, row_pitch});
            dist_sum[k] = {1'b0, d_sx_reg[k]} + {1'b0, d_sy_reg[k]};
        end
        pick = !(dist_sum[0] < dist_sum[1]);
        out_next.cell_col = d_ka_reg[pick][hcl_pkg::POS_W:1];
        out_next.cell_row = d_kr_reg[pick][hcl_pkg::POS_W-1:0];
        out_next.found    = d_fnd_reg && (half_width != '0) && (row_pitch != '0);
        if (!out_next.found) begin
            out_next.cell_col = '0;
            out_next.cell_row = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_fnd_reg <= fnd_next;
            a_x_reg   <= quot.meta.pos_x;
            a_y_reg   <= quot.meta.pos_y;
            b_fnd_reg <= a_fnd_reg;
            b_x_reg   <= a_x_reg;
            b_y_reg   <= a_y_reg;
            c_fnd_reg <= b_fnd_reg;
            d_fnd_reg <= c_fnd_reg;
            e_out_reg <= out_next;
            for (int k = 0; k < 2; k++) begin
                a_ka_reg[k] <= ka_next[k];
                a_kr_reg[k] <= kr_next[k];
                b_px_reg[k] <= prod_x[k][PW-1:0];
                b_py_reg[k] <= prod_y[k][PW-1:0];
                b_ka_reg[k] <= a_ka_reg[k];
                b_kr_reg[k] <= a_kr_reg[k];
                c_dx_reg[k] <= b_px_reg[k] - PW'(b_x_reg);
                c_dy_reg[k] <= b_py_reg[k] - PW'(b_y_reg);
                c_ka_reg[k] <= b_ka_reg[k];
                c_kr_reg[k] <= b_kr_reg[k];
                d_sx_reg[k] <= SW'(c_dx_reg[k] * c_dx_reg[k]);
                d_sy_reg[k] <= SW'(c_dy_reg[k] * c_dy_reg[k]);
                d_ka_reg[k] <= c_ka_reg[k];
                d_kr_reg[k] <= c_kr_reg[k];
            end
        end
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= quot.valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
        end
    end

    assign out_valid = e_vld_reg;
    assign out_data  = e_out_reg;

endmodule

// ----- design/hex_cell_locator.sv -----
// hex_cell_locator: nearest hexagon centre on an offset-row grid (top level).
// Depends on hcl_pkg, hcl_divider and hcl_nearest.
//
//  channel  | ports                                    | word
//  ---------+------------------------------------------+-------------------------
//  input    | s_valid, s_ready, s_data                 | pos_x, pos_y
//  result   | m_valid, m_ready, m_data                 | cell_col, cell_row, found
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | half_width / row_pitch
//
// One word per cycle while the result is not stalled; stages in order: input register,
// 16 divider stages, then corner select, position multiply, offset, square, compare/output.
// The 16-stage restoring divider, one quotient bit per stage, sets the depth.
// Reset (aresetn low, synchronous) clears all valid bits and loads
// half_width = 50, row_pitch = 86.
// A stalled result (m_valid && !m_ready) freezes every stage; s_ready drops
// in the same cycle, so no word is lost or repeated.
// Config writes are always taken; change them only with the pipe empty.
module hex_cell_locator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  hcl_pkg::hcl_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output hcl_pkg::hcl_out_t                m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hcl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hcl_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [hcl_pkg::HW_W-1:0]  half_width_reg;
    logic [hcl_pkg::RP_W-1:0]  row_pitch_reg;

    logic                      in_vld_reg;
    hcl_pkg::hcl_meta_t        in_meta_reg;
    logic [hcl_pkg::POS_W-1:0] x_mag_reg, y_mag_reg;
    hcl_pkg::hcl_meta_t        meta_next;
    logic [hcl_pkg::POS_W-1:0] x_mag_next, y_mag_next;

    hcl_pkg::hcl_quot_t        quot;
    logic                      en;

    // whole pipe advances unless the output word is held
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg <= hcl_pkg::HALF_WIDTH_RST;
            row_pitch_reg  <= hcl_pkg::ROW_PITCH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                hcl_pkg::CFG_HALF_WIDTH: half_width_reg <= cfg_data[hcl_pkg::HW_W-1:0];
                hcl_pkg::CFG_ROW_PITCH:  row_pitch_reg  <= cfg_data[hcl_pkg::RP_W-1:0];
                default: ;
            endcase
        end
    end

    // sign / magnitude split; -32768 maps to magnitude 32768
    always_comb begin
        meta_next.neg_x = s_data.pos_x[hcl_pkg::POS_W-1];
        meta_next.neg_y = s_data.pos_y[hcl_pkg::POS_W-1];
        meta_next.nz_x  = (s_data.pos_x != '0);
        meta_next.nz_y  = (s_data.pos_y != '0);
        meta_next.pos_x = s_data.pos_x;
        meta_next.pos_y = s_data.pos_y;
        x_mag_next = meta_next.neg_x ? -s_data.pos_x : s_data.pos_x;
        y_mag_next = meta_next.neg_y ? -s_data.pos_y : s_data.pos_y;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_meta_reg <= meta_next;
            x_mag_reg   <= x_mag_next;
            y_mag_reg   <= y_mag_next;
        end
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_valid;
        end
    end

    hcl_divider u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (in_vld_reg),
        .in_meta    (in_meta_reg),
        .x_mag      (x_mag_reg),
        .y_mag      (y_mag_reg),
        .half_width (half_width_reg),
        .row_pitch  (row_pitch_reg),
        .quot       (quot)
    );

    hcl_nearest u_near (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .quot       (quot),
        .half_width (half_width_reg),
        .row_pitch  (row_pitch_reg),
        .out_valid  (m_valid),
        .out_data   (m_data)
    );

`ifndef SYNTH
    a_found_needs_regs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> half_width_reg != '0 && row_pitch_reg != '0)
        else $error("found set with a zero spacing register");
    a_empty_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("held result word changed or dropped");
    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.cell_col == '0 && m_data.cell_row == '0)
        else $error("indices nonzero without a found cell");
`endif

endmodule
